### hw/rtl/dvle_pkg.sv
// Shared constants and types for the delta varint list encoder.
// No dependencies; every other file of the block imports this package.
package dvle_pkg;

  localparam int unsigned ID_BITS_DEF = 32;  // default id width inside the block
  localparam int unsigned NODE_W      = 32;  // node_id and head_id port width
  localparam int unsigned CODE_W      = 8;   // code_byte width
  localparam int unsigned GROUP_W     = 7;   // payload bits per code byte

  localparam logic KIND_HEAD = 1'b0;
  localparam logic KIND_CODE = 1'b1;

  // Handoff from the serial subtractor to the byte emitter.
  typedef struct packed {
    logic valid;
    logic is_head;
  } dvle_hand_t;

endpackage

### hw/rtl/dvle_if.sv
// Valid/ready channel interfaces for the delta varint list encoder.
// Depends on dvle_pkg for the field widths.
interface dvle_in_if;
  import dvle_pkg::*;

  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   node_id;
  logic                list_start;

  modport source (output valid, output node_id, output list_start, input ready);
  modport sink   (input valid, input node_id, input list_start, output ready);
endinterface

interface dvle_out_if;
  import dvle_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [NODE_W-1:0]   head_id;
  logic [CODE_W-1:0]   code_byte;
  logic                last_of_run;

  modport source (output valid, output kind, output head_id, output code_byte,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input head_id, input code_byte,
                  input last_of_run, output ready);
endinterface

### hw/rtl/delta_varint_list_encoder_top.sv
// Delta varint list encoder, top level. Uses dvle_pkg, dvle_if, dvle_sub, dvle_emit.
// Path: a head goes through S_HOLD in the subtractor and the emitter's register;
//   a difference first runs the digit loop, N = ceil(IdBits/7) (N = 5 at 32 bits).
// Throughput: the subtractor takes one item at a time, until the emitter takes it;
//   bytes leave at one per cycle while out_o.ready is high and overlap the next item.
// Reset: rst_ni low clears the previous id to zero and empties both stages.
module delta_varint_list_encoder_top #(
  parameter int unsigned IdBits = dvle_pkg::ID_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvle_in_if.sink    in_i,
  dvle_out_if.source out_o
);
  import dvle_pkg::*;

  // Handoff between the subtractor and the emitter: valid/kind as a struct,
  // the difference (or raw head id) alongside it.
  dvle_hand_t        hand;
  logic              hand_ready;
  logic [IdBits-1:0] hand_value;

  // Stage 1: hold the previous id and form the difference digit by digit.
  dvle_sub #(
    .IdBits (IdBits)
  ) u_sub (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .hand_o       (hand),
    .hand_ready_i (hand_ready),
    .value_o      (hand_value)
  );

  // Stage 2: drop zero differences, emit head ids and varint bytes.
  dvle_emit #(
    .IdBits (IdBits)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hand_i       (hand),
    .hand_ready_o (hand_ready),
    .value_i      (hand_value),
    .out_o        (out_o)
  );

  // A head result is a single beat with an empty code byte.
  a_head_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_HEAD) |-> out_o.last_of_run && (out_o.code_byte == '0))
    else $error("head result without last_of_run or with a code byte");

  // The continuation bit of a code byte is the inverse of last_of_run.
  a_cont_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_CODE) |-> (out_o.code_byte[CODE_W-1] != out_o.last_of_run))
    else $error("continuation bit disagrees with last_of_run");

  // Code bytes carry no head id.
  a_code_no_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_CODE) |-> (out_o.head_id == '0))
    else $error("code byte result carries a head id");

  // The subtractor works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while the subtractor is busy");

endmodule

### hw/rtl/dvle_sub.sv
// Digit-serial subtractor: forms new id minus previous id, 7 bits per cycle.
// Head ids pass through unchanged. Depends on dvle_pkg and dvle_in_if.
module dvle_sub #(
  parameter int unsigned IdBits = dvle_pkg::ID_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dvle_in_if.sink              in_i,
  output dvle_pkg::dvle_hand_t hand_o,
  input  logic                 hand_ready_i,
  output logic [IdBits-1:0]    value_o
);
  import dvle_pkg::*;

  localparam int unsigned NumDig = (IdBits + GROUP_W - 1) / GROUP_W;
  localparam int unsigned DigW   = NumDig * GROUP_W;
  localparam int unsigned CntW   = $clog2(NumDig);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_HOLD = 3'b100
  } sub_state_e;

  sub_state_e          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                borrow_q, borrow_d;
  logic                head_q, head_d;
  logic [IdBits-1:0]   prev_q, prev_d;
  logic [DigW-1:0]     a_q, a_d;
  logic [DigW-1:0]     b_q, b_d;
  logic [DigW-1:0]     delta_q, delta_d;
  logic [GROUP_W:0]    digit;
  logic [IdBits-1:0]   id_in;

  assign id_in = IdBits'(in_i.node_id);
  assign digit = {1'b0, a_q[GROUP_W-1:0]} - {1'b0, b_q[GROUP_W-1:0]}
                 - {{GROUP_W{1'b0}}, borrow_q};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    borrow_d = borrow_q;
    head_d   = head_q;
    prev_d   = prev_q;
    a_d      = a_q;
    b_d      = b_q;
    delta_d  = delta_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          prev_d = id_in;
          if (in_i.list_start) begin
            head_d  = 1'b1;
            delta_d = DigW'(id_in);
            state_d = S_HOLD;
          end else begin
            head_d   = 1'b0;
            a_d      = DigW'(id_in);
            b_d      = DigW'(prev_q);
            borrow_d = 1'b0;
            cnt_d    = CntW'(NumDig - 1);
            state_d  = S_CALC;
          end
        end
      end
      S_CALC: begin
        // advance one digit; the result shifts in from the top
        borrow_d = digit[GROUP_W];
        a_d      = a_q >> GROUP_W;
        b_d      = b_q >> GROUP_W;
        delta_d  = {digit[GROUP_W-1:0], delta_q[DigW-1:GROUP_W]};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (hand_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    borrow_q <= borrow_d;
    head_q   <= head_d;
    a_q      <= a_d;
    b_q      <= b_d;
    delta_q  <= delta_d;
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign hand_o.valid   = (state_q == S_HOLD);
  assign hand_o.is_head = head_q;
  // drop the borrow bits that ran past the id width
  assign value_o        = delta_q[IdBits-1:0];

endmodule

### hw/rtl/dvle_emit.sv
// Byte emitter: shifts the difference out 7 bits per beat as varint bytes, or passes a head id out as one beat.
// Zero differences are dropped. Depends on dvle_pkg and dvle_out_if.
module dvle_emit #(
  parameter int unsigned IdBits = dvle_pkg::ID_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dvle_pkg::dvle_hand_t hand_i,
  output logic                 hand_ready_o,
  input  logic [IdBits-1:0]    value_i,
  dvle_out_if.source           out_o
);
  import dvle_pkg::*;

  logic              busy_q, busy_d;
  logic              kind_q, kind_d;
  logic [IdBits-1:0] sr_q, sr_d;
  logic              rest_nz;
  logic              beat;
  logic              done;

  assign rest_nz      = |sr_q[IdBits-1:GROUP_W];
  assign beat         = out_o.valid & out_o.ready;
  assign done         = beat & out_o.last_of_run;
  assign hand_ready_o = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    kind_d = kind_q;
    sr_d   = sr_q;
    if (beat) begin
      sr_d = sr_q >> GROUP_W;
      if (done) begin
        busy_d = 1'b0;
      end
    end
    if (hand_i.valid && hand_ready_o) begin
      sr_d = value_i;
      if (hand_i.is_head) begin
        busy_d = 1'b1;
        kind_d = KIND_HEAD;
      end else begin
        // a zero difference is a repeated id: drop it
        busy_d = (value_i != '0);
        kind_d = KIND_CODE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    sr_q   <= sr_d;
  end

  assign out_o.valid       = busy_q;
  assign out_o.kind        = kind_q;
  assign out_o.head_id     = (kind_q == KIND_HEAD) ? NODE_W'(sr_q) : '0;
  assign out_o.code_byte   = (kind_q == KIND_CODE) ? {rest_nz, sr_q[GROUP_W-1:0]} : '0;
  assign out_o.last_of_run = (kind_q == KIND_HEAD) ? 1'b1 : !rest_nz;

endmodule

### bench/varint_stream_checker.sv
`timescale 1ns / 100ps
// Stream checker for the delta varint list encoder: watches both channels and
// predicts the head and code-byte beats of every accepted id, then compares them in order.
// Depends on dvle_pkg and on the dvle_in_if / dvle_out_if interfaces.
module varint_stream_checker #(
  parameter int unsigned IdBits = dvle_pkg::ID_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  dvle_in_if   in_i,
  dvle_out_if  out_i,
  output int   fail_count_o,
  output int   pending_o
);
  import dvle_pkg::*;

  localparam logic [CODE_W-1:0] MORE_FLAG  = 8'h80;
  localparam logic [NODE_W-1:0] GROUP_MASK = NODE_W'(8'h7F);
  localparam logic [NODE_W-1:0] ID_MASK    =
      (IdBits >= NODE_W) ? '1 : NODE_W'((64'd1 << IdBits) - 64'd1);

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] head_id;
    logic [CODE_W-1:0] code_byte;
    logic              last_of_run;
  } enc_beat_t;

  enc_beat_t         expected_beats[$];
  logic [NODE_W-1:0] prev_id;
  int                mismatches = 0;

  task automatic flag_mismatch(input string what, input logic [NODE_W-1:0] got,
                               input logic [NODE_W-1:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Work out the beats one accepted id causes and update the previous id.
  task automatic encode_id(input logic [NODE_W-1:0] raw_id, input logic start);
    logic [NODE_W-1:0] id;
    logic [NODE_W-1:0] delta;
    logic [NODE_W-1:0] rest;
    enc_beat_t         beat;
    id = raw_id & ID_MASK;
    if (start) begin
      prev_id          = id;
      beat.kind        = KIND_HEAD;
      beat.head_id     = id;
      beat.code_byte   = '0;
      beat.last_of_run = 1'b1;
      expected_beats.insert(expected_beats.size(), beat);
    end else if (id != prev_id) begin
      delta   = (id - prev_id) & ID_MASK;
      prev_id = id;
      while (delta != '0) begin
        rest             = delta >> GROUP_W;
        beat.kind        = KIND_CODE;
        beat.head_id     = '0;
        beat.code_byte   = CODE_W'(delta & GROUP_MASK) | ((rest != '0) ? MORE_FLAG : '0);
        beat.last_of_run = (rest == '0);
        expected_beats.insert(expected_beats.size(), beat);
        delta = rest;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    enc_beat_t want;
    if (!rst_ni) begin
      prev_id = '0;
      expected_beats.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (in_i.valid && in_i.ready) begin
        encode_id(in_i.node_id, in_i.list_start);
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch("beat with nothing expected, code_byte",
                        NODE_W'(out_i.code_byte), '0);
        end else begin
          want = expected_beats.pop_front();
          if (out_i.kind !== want.kind)
            flag_mismatch("kind", NODE_W'(out_i.kind), NODE_W'(want.kind));
          if (out_i.head_id !== want.head_id)
            flag_mismatch("head_id", out_i.head_id, want.head_id);
          if (out_i.code_byte !== want.code_byte)
            flag_mismatch("code_byte", NODE_W'(out_i.code_byte), NODE_W'(want.code_byte));
          if (out_i.last_of_run !== want.last_of_run)
            flag_mismatch("last_of_run", NODE_W'(out_i.last_of_run),
                          NODE_W'(want.last_of_run));
        end
      end
      pending_o    <= expected_beats.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the delta varint list encoder bench: clock, reset, id stimulus and the verdict.
// Depends on dvle_pkg, dvle_if, the encoder RTL and varint_stream_checker.
module testbench;
  import dvle_pkg::*;

  localparam int RANDOM_ITEMS = 360;
  localparam int HOLD_CYCLES  = 150;  // receiver hold-off, long enough to back up the input
  localparam int DRAIN_CYCLES = 20;   // extra wait after the checker has drained, for late beats to show

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  // Shared between the sender and the receiver: idle rate in percent, and the
  // request for one long receiver hold-off.
  int   idle_pct = 19;
  bit   squeeze  = 1'b0;

  logic [NODE_W-1:0] last_id;

  dvle_in_if  in_ch ();
  dvle_out_if out_ch ();

  delta_varint_list_encoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  varint_stream_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs or drops beats.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Offer one id beat, idling at random first, and hold it until it is taken.
  // valid is left high after the beat, so back-to-back beats keep it high with no gap.
  task automatic send_item(input logic [NODE_W-1:0] id, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.node_id    <= id;
    in_ch.list_start <= start;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    last_id = id;
  endtask

  // Advance the current list by a given difference.
  task automatic step_by(input logic [NODE_W-1:0] delta);
    send_item(last_id + delta, 1'b0);
  endtask

  // Pick a nonzero difference that encodes to exactly nbytes code bytes.
  function automatic logic [NODE_W-1:0] delta_of_bytes(input int nbytes);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = 64'd1 << (GROUP_W * (nbytes - 1));
    hi = (nbytes >= 5) ? 64'hFFFF_FFFF : (64'd1 << (GROUP_W * nbytes)) - 64'd1;
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  // Receiver: ready at random, with one long hold-off on request so the encoder
  // fills up and stalls its input while the sender keeps offering ids.
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze && !held_off) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    int sent;
    int list_len;
    int pick;
    int lists;
    rst_ni <= 1'b0;
    last_id = '0;
    in_ch.valid      <= 1'b0;
    in_ch.node_id    <= '0;
    in_ch.list_start <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Before any head the previous id is zero: a zero id makes
    // nothing and a small id is sent as a difference from zero.
    send_item('0, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b0);              // repeat: no beat
    send_item('0, 1'b1);                 // head of zero
    send_item(32'hFFFF_FFFF, 1'b0);      // difference of FFFF_FFFF, five bytes
    send_item(32'hFFFF_FFFF, 1'b1);      // head of all ones
    send_item('0, 1'b0);                 // wraps around to a difference of one
    // Each byte-count boundary, from both sides.
    step_by(32'd127);
    step_by(32'd128);
    step_by(32'd16383);
    step_by(32'd16384);
    step_by(32'h001F_FFFF);
    step_by(32'h0020_0000);
    step_by(32'h0FFF_FFFF);
    step_by(32'h1000_0000);
    send_item(32'd10, 1'b0);             // descending id wraps
    send_item(32'hA5A5_A5A5, 1'b1);
    send_item(32'hA5A5_A5A5, 1'b0);      // repeat of the head
    send_item(32'h5A5A_5A5A, 1'b1);
    step_by(32'd1);

    // Random part: mostly well-formed lists with random heads and differences
    // of every length, with repeats, descents and headless noise mixed in.
    sent  = 0;
    lists = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = (sent >= 120 && sent < 200) ? 0 : 19;
      if (lists == 3) squeeze = 1'b1;
      lists++;
      if ($urandom_range(9) == 0) begin
        // Noise: ids with no head, against whatever previous id is held.
        repeat ($urandom_range(3, 1)) begin
          send_item($urandom, 1'b0);
          sent++;
        end
      end else begin
        send_item($urandom, 1'b1);
        sent++;
        list_len = $urandom_range(8, 1);
        repeat (list_len) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            send_item(last_id, 1'b0);    // repeat: ignored, not counted
          end else if (pick < 14) begin
            send_item(last_id - $urandom_range(1000, 1), 1'b0);
            sent++;
          end else begin
            step_by(delta_of_bytes($urandom_range(5, 1)));
            sent++;
          end
        end
      end
    end

    // Drop valid, drain every expected beat, then give late beats time to show.
    in_ch.valid <= 1'b0;
    idle_pct = 19;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
